FILE: rtl/crc_polynomial_remainder_top_defines.svh
// Assertion macros shared by the CRC remainder RTL.
`ifndef CRC_POLYNOMIAL_REMAINDER_TOP_DEFINES_SVH
`define CRC_POLYNOMIAL_REMAINDER_TOP_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define CRC_PR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CRC_PR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/crc_pr_pkg.sv
`timescale 1ns / 1ps

package crc_pr_pkg;

    localparam int DEFAULT_MAX_DEGREE = 32;
    localparam int GEN_W     = 33;   // explicit generator incl. leading term
    localparam int REM_W     = 32;   // remainder port width
    localparam int DEG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMPLICIT  = 1'b1;

    // per-cell configuration, decoded once per config write
    typedef struct packed {
        logic active;    // cell lies below the degree
        logic tap;       // generator coefficient at this position
        logic top_sel;   // cell holds the top remainder bit
    } cell_cfg_t;

endpackage

FILE: rtl/crc_polynomial_remainder_top.sv
// Bit-serial CRC remainder: divides a message, one bit per beat with the
// most significant bit first, by a programmable GF(2) generator of degree up
// to min(MAX_DEGREE, 32). Throughput is one message bit per clock: each bit
// goes through a single shift-and-conditional-XOR across the row of
// remainder cells, one flip-flop per cell. A beat with is_last set yields
// one result beat (remainder right-aligned, plus the degree) in the next
// cycle through an output register, and the running remainder clears for
// the next message with no gap. Input stalls only while a result waits
// unclaimed. The generator and its form (explicit, or implicit with the
// constant term omitted) are decoded into per-cell taps when written; the
// new setting applies from the next beat on.
`timescale 1ns / 1ps
`include "crc_polynomial_remainder_top_defines.svh"

module crc_polynomial_remainder_top
#(
    parameter int MAX_DEGREE = crc_pr_pkg::DEFAULT_MAX_DEGREE
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crc_pr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [crc_pr_pkg::GEN_W-1:0]     cfg_data,
    // message bits
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             msg_bit,
    input  logic                             is_last,
    // results
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [crc_pr_pkg::REM_W-1:0]     crc_remainder,
    output logic [crc_pr_pkg::DEG_W-1:0]     poly_degree
);

    // number of remainder cells actually reachable by the degree
    localparam int CELLS = (MAX_DEGREE < crc_pr_pkg::REM_W) ? MAX_DEGREE
                                                           : crc_pr_pkg::REM_W;

    crc_pr_pkg::cell_cfg_t [CELLS-1:0] cell_cfg;
    logic [crc_pr_pkg::DEG_W-1:0]      degree;
    logic [CELLS-1:0]                  rem_q;      // running remainder
    logic [CELLS-1:0]                  rem_next;
    logic [CELLS-1:0]                  left_in;    // each cell's feed from below
    logic [CELLS-1:0]                  top_sel;
    logic [CELLS-1:0]                  active;
    logic                              top_bit;
    logic                              step;

    logic                              out_valid_reg, out_valid_next;
    logic [crc_pr_pkg::REM_W-1:0]      crc_reg;
    logic [crc_pr_pkg::DEG_W-1:0]      deg_reg;

    // config writes are registered when taken; never back-pressured
    assign cfg_ready = 1'b1;

    crc_pr_poly
    #(
        .MAX_DEGREE (MAX_DEGREE),
        .CELLS      (CELLS)
    )
    u_poly
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cell_cfg  (cell_cfg),
        .degree    (degree)
    );

    // accept while the output slot is free or being drained this cycle
    assign in_ready = ~out_valid_reg | out_ready;
    assign step     = in_valid & in_ready;

    // the bit falling off the top is picked by top_sel, one-hot for a nonzero degree
    always_comb
    begin
        for (int j = 0; j < CELLS; j++)
        begin
            top_sel[j] = cell_cfg[j].top_sel;
            active[j]  = cell_cfg[j].active;
        end
        top_bit = |(rem_q & top_sel);
    end

    // message bit enters cell 0, each cell feeds the one above
    generate
        for (genvar g = 0; g < CELLS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                assign left_in[g] = msg_bit;
            end
            else
            begin : g_rest
                assign left_in[g] = rem_q[g-1];
            end

            crc_pr_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .step     (step),
                .clear    (is_last),
                .left_bit (left_in[g]),
                .top_bit  (top_bit),
                .cfg      (cell_cfg[g]),
                .bit_q    (rem_q[g]),
                .bit_next (rem_next[g])
            );
        end
    endgenerate

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (step && is_last)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && is_last)
        begin
            crc_reg <= crc_pr_pkg::REM_W'(rem_next);
            deg_reg <= degree;
        end
    end

    assign out_valid     = out_valid_reg;
    assign crc_remainder = crc_reg;
    assign poly_degree   = deg_reg;

    // a waiting result must stall the input
    `CRC_PR_ASSERT(a_stall_on_full,
        (out_valid_reg && !out_ready) |-> !in_ready, "input taken while result stuck")
    // last beat always produces a result next cycle
    `CRC_PR_ASSERT(a_last_gives_result,
        (step && is_last) |=> out_valid_reg, "last beat lost its result")
    // after a beat under a steady setting, cells above the degree are cleared;
    // a narrower setting leaves stale bits up there until the next beat
    `CRC_PR_ASSERT(a_rem_in_degree,
        $past(step && !(cfg_valid && cfg_ready)) |-> ((rem_q & ~active) == '0),
        "remainder bit above degree")
    // exactly one top cell unless degree is zero
    `CRC_PR_ASSERT_ALWAYS(a_top_sel,
        $onehot0(top_sel) && ((top_sel == '0) == (degree == '0)), "bad top cell select")

endmodule

FILE: rtl/crc_pr_cell.sv
`timescale 1ns / 1ps

module crc_pr_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,      // beat accepted
    input  logic                 clear,     // last bit of message
    input  logic                 left_bit,  // neighbor below, or message bit
    input  logic                 top_bit,   // bit leaving the top
    input  crc_pr_pkg::cell_cfg_t cfg,
    output logic                 bit_q,
    output logic                 bit_next
);

    logic bit_reg;

    assign bit_next = cfg.active & (left_bit ^ (top_bit & cfg.tap));
    assign bit_q    = bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else if (step)
        begin
            bit_reg <= clear ? 1'b0 : bit_next;
        end
    end

endmodule

FILE: rtl/crc_pr_poly.sv
`timescale 1ns / 1ps

module crc_pr_poly
#(
    parameter int MAX_DEGREE = crc_pr_pkg::DEFAULT_MAX_DEGREE,
    parameter int CELLS      = (MAX_DEGREE < crc_pr_pkg::REM_W) ? MAX_DEGREE
                                                                : crc_pr_pkg::REM_W
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [crc_pr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [crc_pr_pkg::GEN_W-1:0]        cfg_data,
    output crc_pr_pkg::cell_cfg_t [CELLS-1:0]   cell_cfg,
    output logic [crc_pr_pkg::DEG_W-1:0]        degree
);

    logic [crc_pr_pkg::GEN_W-1:0]         generator_reg, generator_next;
    logic                                 implicit_reg, implicit_next;
    logic [crc_pr_pkg::GEN_W-1:0]         poly;
    logic [crc_pr_pkg::DEG_W-1:0]         degree_reg, degree_next;
    crc_pr_pkg::cell_cfg_t [CELLS-1:0]    cell_cfg_reg, cell_cfg_next;

    always_comb
    begin
        generator_next = generator_reg;
        implicit_next  = implicit_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                crc_pr_pkg::REG_GENERATOR: generator_next = cfg_data;
                crc_pr_pkg::REG_IMPLICIT:  implicit_next  = cfg_data[0];
                default: ;
            endcase
        end
    end

    // polynomial value, cut to MAX_DEGREE+1 bits, its degree and per-cell config
    always_comb
    begin
        poly = implicit_next ? {generator_next[crc_pr_pkg::GEN_W-2:0], 1'b1}
                             : generator_next;
        for (int i = 0; i < crc_pr_pkg::GEN_W; i++)
        begin
            if (i > MAX_DEGREE)
                poly[i] = 1'b0;
        end
        degree_next = '0;
        for (int i = 1; i < crc_pr_pkg::GEN_W; i++)
        begin
            if (poly[i])
                degree_next = crc_pr_pkg::DEG_W'(i);
        end
        for (int j = 0; j < CELLS; j++)
        begin
            cell_cfg_next[j].active  = crc_pr_pkg::DEG_W'(j) < degree_next;
            cell_cfg_next[j].top_sel = crc_pr_pkg::DEG_W'(j + 1) == degree_next;
            cell_cfg_next[j].tap     = poly[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            generator_reg <= '0;
            implicit_reg  <= 1'b0;
            degree_reg    <= '0;
            cell_cfg_reg  <= '0;
        end
        else if (cfg_write)
        begin
            generator_reg <= generator_next;
            implicit_reg  <= implicit_next;
            degree_reg    <= degree_next;
            cell_cfg_reg  <= cell_cfg_next;
        end
    end

    assign cell_cfg = cell_cfg_reg;
    assign degree   = degree_reg;

endmodule

FILE: bench/crc_remainder_checker.sv
`timescale 1ns / 1ps

// Watches the config, message and result channels, predicts each result
// from its own copy of the divisor setting and remainder, and compares.
module crc_remainder_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [crc_pr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [crc_pr_pkg::GEN_W-1:0]     cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             msg_bit,
    input  logic                             is_last,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [crc_pr_pkg::REM_W-1:0]     crc_remainder,
    input  logic [crc_pr_pkg::DEG_W-1:0]     poly_degree,
    output int                               mismatch_count,
    output int                               results_pending
);

    typedef struct packed {
        logic [crc_pr_pkg::REM_W-1:0] remainder;
        logic [crc_pr_pkg::DEG_W-1:0] degree;
    } crc_result_t;

    crc_result_t                  expected_crcs[$];
    logic [crc_pr_pkg::GEN_W-1:0] gen_value;
    logic                         implicit_sel;
    logic [crc_pr_pkg::REM_W-1:0] running_rem;
    int                           err_cnt;

    // implicit form: constant term appended, bit 32 of the register dropped
    function automatic logic [crc_pr_pkg::GEN_W-1:0] divisor_poly(
        logic [crc_pr_pkg::GEN_W-1:0] g, logic impl);
        return impl ? {g[crc_pr_pkg::REM_W-1:0], 1'b1} : g;
    endfunction

    function automatic int unsigned divisor_degree(logic [crc_pr_pkg::GEN_W-1:0] p);
        int unsigned d = 0;
        for (int i = 1; i < crc_pr_pkg::GEN_W; i++)
        begin
            if (p[i])
                d = i;
        end
        return d;
    endfunction

    function automatic void divide_bit(logic b, logic last);
        logic [crc_pr_pkg::GEN_W-1:0] p;
        int unsigned                  n;
        logic [63:0]                  mask;
        logic [63:0]                  r;
        logic                         top;
        crc_result_t                  res;
        p = divisor_poly(gen_value, implicit_sel);
        n = divisor_degree(p);
        if (n == 0)
        begin
            running_rem = '0;
        end
        else
        begin
            mask = (64'd1 << n) - 64'd1;
            // a new, narrower divisor cuts the remainder first
            r    = {32'd0, running_rem} & mask;
            top  = r[n-1];
            r    = ((r << 1) | {63'd0, b}) & mask;
            if (top)
                r = r ^ ({31'd0, p} & mask);
            running_rem = r[crc_pr_pkg::REM_W-1:0];
        end
        if (last)
        begin
            res.remainder = running_rem;
            res.degree    = n[crc_pr_pkg::DEG_W-1:0];
            expected_crcs.push_back(res);
            running_rem = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        crc_result_t want;
        if (!rst_n)
        begin
            gen_value    = '0;
            implicit_sel = 1'b0;
            running_rem  = '0;
            err_cnt      = 0;
            expected_crcs.delete();
        end
        else
        begin
            // a result beat always comes from an earlier message beat
            if (out_valid && out_ready)
            begin
                if (expected_crcs.size() == 0)
                begin
                    $display("%t: unexpected result beat remainder %h degree %0d",
                             $time, crc_remainder, poly_degree);
                    err_cnt++;
                end
                else
                begin
                    want = expected_crcs.pop_front();
                    if (crc_remainder !== want.remainder)
                    begin
                        $display("%t: crc_remainder expected %h actual %h",
                                 $time, want.remainder, crc_remainder);
                        err_cnt++;
                    end
                    if (poly_degree !== want.degree)
                    begin
                        $display("%t: poly_degree expected %0d actual %0d",
                                 $time, want.degree, poly_degree);
                        err_cnt++;
                    end
                end
            end
            // a beat taken on the same edge as a write still sees the old setting
            if (in_valid && in_ready)
                divide_bit(msg_bit, is_last);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == crc_pr_pkg::REG_GENERATOR)
                    gen_value = cfg_data;
                else if (cfg_index == crc_pr_pkg::REG_IMPLICIT)
                    implicit_sel = cfg_data[0];
            end
        end
        mismatch_count  <= err_cnt;
        results_pending <= expected_crcs.size();
    end

endmodule

FILE: bench/crc_polynomial_remainder_top_test.sv
`timescale 1ns / 1ps

// Drives message bits and divisor settings into the CRC remainder block;
// the checker beside it predicts every result and counts mismatches.
module crc_polynomial_remainder_top_test;

    localparam int PHASES       = 16;
    localparam int PHASE_BEATS  = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_ITEMS = 4;    // result shows up in the cycle after its beat

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [crc_pr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [crc_pr_pkg::GEN_W-1:0]     cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic                             msg_bit;
    logic                             is_last;
    logic                             out_valid;
    logic                             out_ready;
    logic [crc_pr_pkg::REM_W-1:0]     crc_remainder;
    logic [crc_pr_pkg::DEG_W-1:0]     poly_degree;

    int mismatch_count;
    int results_pending;

    // idle rates in percent, per phase
    int send_idle  = 0;
    int recv_stall = 0;
    // bumped by the stimulus to start one long receiver hold-off
    int hold_req   = 0;

    int msg_left   = 0;     // bits still to go in the current message
    int msg_max    = 24;    // longest message for the random part

    always #4 clk = ~clk;

    crc_polynomial_remainder_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .msg_bit       (msg_bit),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .crc_remainder (crc_remainder),
        .poly_degree   (poly_degree)
    );

    crc_remainder_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .msg_bit         (msg_bit),
        .is_last         (is_last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .crc_remainder   (crc_remainder),
        .poly_degree     (poly_degree),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Offer one message beat. A random gap may come first; with no gap the
    // valid simply stays high and the payload moves on to the next bit.
    task automatic send_bit(input logic b, input logic last);
        if ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        in_valid <= 1'b1;
        msg_bit  <= b;
        is_last  <= last;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Next bit of the random stream. Messages run across phase boundaries,
    // so a divisor change in the middle of a message happens on its own.
    task automatic send_stream_bit();
        if (msg_left == 0)
        begin
            if ($urandom_range(0, 9) == 0 && msg_max > 24)
                msg_left = $urandom_range(40, msg_max);
            else
                msg_left = $urandom_range(1, (msg_max > 24) ? 24 : msg_max);
        end
        send_bit($urandom_range(0, 1), msg_left == 1);
        msg_left--;
    endtask

    // Stop the message stream and wait until every predicted result has
    // been taken. The first edge lets the checker count a final last beat.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_ITEMS) @(posedge clk);
    endtask

    // Both registers, back to back; valid stays high across the two beats.
    task automatic set_divisor(input logic [crc_pr_pkg::GEN_W-1:0] gen, input logic impl);
        cfg_valid <= 1'b1;
        cfg_index <= crc_pr_pkg::REG_GENERATOR;
        cfg_data  <= gen;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= crc_pr_pkg::REG_IMPLICIT;
        cfg_data  <= crc_pr_pkg::GEN_W'(impl);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Explicit generator of a chosen degree: random taps below the top term.
    function automatic logic [crc_pr_pkg::GEN_W-1:0] explicit_gen(int unsigned deg);
        logic [crc_pr_pkg::GEN_W-1:0] g;
        g = {1'($urandom_range(0, 1)), 32'($urandom)};
        return (g & ((crc_pr_pkg::GEN_W'(1) << deg) - crc_pr_pkg::GEN_W'(1)))
               | (crc_pr_pkg::GEN_W'(1) << deg);
    endfunction

    // Receiver: random stalls, plus a long hold-off when asked for.
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall);
            end
        end
    end

    initial
    begin
        logic [crc_pr_pkg::GEN_W-1:0] gen;
        logic                         impl;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= crc_pr_pkg::REG_GENERATOR;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        msg_bit   <= 1'b0;
        is_last   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Registers still at reset: zero generator, degree 0, remainder 0.
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b1);
        drain();

        // CRC-8: a message shorter than degree+1 comes back unchanged,
        // down to a one-bit message; a 12-bit random message follows.
        set_divisor(33'h0_0000_0107, 1'b0);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);
        send_bit(1'b1, 1'b1);
        for (int i = 0; i < 12; i++)
            send_bit($urandom_range(0, 1), i == 11);
        drain();

        // Divisor swapped in the middle of a message: the open remainder
        // is kept under the wider new degree and division carries on.
        for (int i = 0; i < 4; i++)
            send_bit(1'b1, 1'b0);
        drain();
        set_divisor(33'h0_0001_1021, 1'b0);
        for (int i = 0; i < 4; i++)
            send_bit($urandom_range(0, 1), i == 3);
        drain();

        // Random part: each phase has its own divisor and idle pattern.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:  begin gen = 33'h1_04C1_1DB7; impl = 1'b0; end  // CRC-32
                1:  begin gen = 33'h0_8260_8EDB; impl = 1'b1; end  // same, implicit
                2:  begin gen = 33'h0_0000_0000; impl = 1'b0; end  // zero generator
                3:  begin gen = 33'h1_FFFF_FFFF; impl = 1'b0; end  // all taps
                4:  begin gen = 33'h1_FFFF_FFFF; impl = 1'b1; end  // bit 32 dropped
                5:  begin gen = 33'h0_0000_0003; impl = 1'b0; end  // x + 1
                6:  begin gen = 33'h0_0000_0002; impl = 1'b0; end  // x, no taps
                7:  begin gen = 33'h0_0000_0000; impl = 1'b1; end  // just 1
                8:  begin gen = 33'h0_0000_0001; impl = 1'b0; end  // just 1
                default:
                begin
                    if (ph % 2 == 1)
                    begin
                        gen  = {1'($urandom_range(0, 1)), 32'($urandom)};
                        impl = 1'b1;
                    end
                    else
                    begin
                        gen  = explicit_gen($urandom_range(1, 32));
                        impl = 1'b0;
                    end
                end
            endcase
            set_divisor(gen, impl);

            // no idling / sender idle / receiver stalls / both lightly
            case (ph % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 53; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 53; end
                default: begin send_idle = 11; recv_stall = 11; end
            endcase

            // One phase of many short messages against a stalled receiver:
            // the result register fills and the input has to back up.
            if (ph == 9)
            begin
                msg_max  = 3;
                // cut a long carried-over message so last beats come early
                if (msg_left > msg_max)
                    msg_left = msg_max;
                hold_req <= hold_req + 1;
            end
            else
            begin
                msg_max = 120;
            end

            for (int k = 0; k < PHASE_BEATS; k++)
                send_stream_bit();
            drain();
        end

        // Close an open message so its result is checked as well.
        while (msg_left > 0)
            send_stream_bit();
        drain();

        if (mismatch_count == 0 && results_pending == 0)
            $display("crc_polynomial_remainder_top test passed");
        else
            $display("crc_polynomial_remainder_top test failed");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("crc_polynomial_remainder_top test failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/crc_pr_pkg.sv
rtl/crc_pr_cell.sv
rtl/crc_pr_poly.sv
rtl/crc_polynomial_remainder_top.sv
bench/crc_remainder_checker.sv
bench/crc_polynomial_remainder_top_test.sv
